// ===== hw/rtl/snoise_pkg.sv =====
`default_nettype none

package snoise_pkg;

  // Permutation table geometry.
  localparam int unsigned PERM_AW      = 8;
  localparam int unsigned PERM_ENTRIES = 1 << PERM_AW;

  // Operation codes carried in the func field.
  typedef logic [1:0] func_t;
  localparam func_t FN_LOAD  = 2'd0;
  localparam func_t FN_EVAL2 = 2'd1;
  localparam func_t FN_EVAL3 = 2'd2;

  // Skew and unskew factors and the 3D falloff radius, unsigned Q0.32.
  localparam logic [31:0] SK_F2  = 32'd1572067139;
  localparam logic [31:0] UN_G2  = 32'd907633386;
  localparam logic [31:0] SK_F3  = 32'd1431655765;
  localparam logic [31:0] UN_G3  = 32'd715827883;
  localparam logic [31:0] RAD_06 = 32'd2576980378;

  // Result field.
  localparam int NOISE_W = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // One gradient component: zero, plus one or minus one.
  localparam logic [1:0] G_ZERO = 2'd0;
  localparam logic [1:0] G_POS  = 2'd1;
  localparam logic [1:0] G_NEG  = 2'd2;

  typedef struct packed {
    logic [1:0] gx;
    logic [1:0] gy;
    logic [1:0] gz;
  } grad_t;

  // Hash byte modulo 12, by multiplication with a scaled reciprocal.
  function automatic logic [3:0] grad_index(input logic [7:0] h);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [8:0]  back;
    logic [7:0]  rem;
    prod = 16'(h) * 16'd171;
    quo  = prod[15:11];
    back = 9'(quo) * 9'd12;
    rem  = h - back[7:0];
    return rem[3:0];
  endfunction

  function automatic grad_t grad_vec(input logic [3:0] g);
    grad_t v;
    case (g)
      4'd0:    v = '{G_POS,  G_POS,  G_ZERO};
      4'd1:    v = '{G_NEG,  G_POS,  G_ZERO};
      4'd2:    v = '{G_POS,  G_NEG,  G_ZERO};
      4'd3:    v = '{G_NEG,  G_NEG,  G_ZERO};
      4'd4:    v = '{G_POS,  G_ZERO, G_POS};
      4'd5:    v = '{G_NEG,  G_ZERO, G_POS};
      4'd6:    v = '{G_POS,  G_ZERO, G_NEG};
      4'd7:    v = '{G_NEG,  G_ZERO, G_NEG};
      4'd8:    v = '{G_ZERO, G_POS,  G_POS};
      4'd9:    v = '{G_ZERO, G_NEG,  G_POS};
      4'd10:   v = '{G_ZERO, G_POS,  G_NEG};
      4'd11:   v = '{G_ZERO, G_NEG,  G_NEG};
      default: v = '{G_ZERO, G_ZERO, G_ZERO};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/simplex_noise_2d_3d.sv =====
`default_nettype none

// Simplex noise evaluator for 2D and 3D points with a loadable 256-entry
// permutation table. Every cycle one item may be taken: busy is always low,
// so a transfer happens at each rising edge where start is high. A load item
// (func 0) writes one table byte and gives no result; a 2D or 3D item gives
// one result, shown on noise_value_o for exactly one cycle while done_o is
// high. Items leave in the order they came in. The rate is one item per
// cycle, through the 19-register pipeline: skew multiply, cell and unskew
// multiply, three levels of table lookups, then the per-corner falloff
// multiplies, the sum and the final scale and saturation. The result side
// cannot hold anything off, so the receiver must take done_o whenever it is
// high. A load only affects items that arrive after it; every table entry
// an evaluation needs must have been loaded before that evaluation arrives.
// Coordinates are signed with FRAC_BITS fraction bits and the result carries
// FRAC_BITS fraction bits.
module simplex_noise_2d_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  snoise_pkg::func_t                    func_i,
  input  logic [snoise_pkg::PERM_AW-1:0]       table_index_i,
  input  logic [snoise_pkg::PERM_AW-1:0]       table_entry_i,
  input  logic signed [47:0]                   coord_x_i,
  input  logic signed [47:0]                   coord_y_i,
  input  logic signed [47:0]                   coord_z_i,
  output logic                                 done_o,
  output logic signed [snoise_pkg::NOISE_W-1:0] noise_value_o
);

  import snoise_pkg::*;

  localparam int F   = FRAC_BITS;
  // Cell offsets stay within a few units, so they are kept modulo 2^XW.
  localparam int XW  = F + 6;
  // Corner offsets: one more bit for the shifts by one unit.
  localparam int CW  = F + 7;
  localparam int SQW = F + 14;
  localparam int TW  = 2 * F + 10;
  localparam int AW2 = TW + 2;
  localparam int SCW = TW + 9;
  localparam int VW  = F + 19;
  localparam int NST = 18;

  localparam logic [63:0] G2FX = (64'(UN_G2) + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] G3FX = (64'(UN_G3) + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] R3FX = (64'(RAD_06) + (64'd1 << (31 - F))) >> (32 - F);

  localparam logic signed [CW-1:0] ONE_C  = CW'(64'd1 << F);
  localparam logic signed [CW-1:0] HALF_C = CW'(64'd1 << (F - 1));
  localparam logic signed [CW-1:0] G2_C   = CW'(G2FX);
  localparam logic signed [CW-1:0] G2X2_C = CW'(2 * G2FX);
  localparam logic signed [CW-1:0] G3_C   = CW'(G3FX);
  localparam logic signed [CW-1:0] G3X2_C = CW'(2 * G3FX);
  localparam logic [F+15:0] RAD2_C = (F+16)'(64'd1 << (F - 1));
  localparam logic [F+15:0] RAD3_C = (F+16)'(R3FX);
  localparam logic [SCW-1:0] RND_C = SCW'(64'd1 << (F - 1));
  localparam logic signed [VW-1:0] VMAX_C = VW'(OUT_MAX);
  localparam logic signed [VW-1:0] VMIN_C = VW'(OUT_MIN);

  typedef struct packed {
    logic [PERM_AW-1:0] ii;
    logic [PERM_AW-1:0] jj;
    logic [PERM_AW-1:0] kk;
  } cell_t;

  // The pipeline never stalls, so a new item is taken in every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Control and load payload travel with each item down the pipeline.
  // ---------------------------------------------------------------------
  logic               vld_q [1:NST];
  func_t              fn_q  [1:NST];
  logic [PERM_AW-1:0] ti_q  [1:12];
  logic [PERM_AW-1:0] te_q  [1:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[1] <= start & ~busy;
      for (int k = 2; k <= NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q[1] <= func_i;
    ti_q[1] <= table_index_i;
    te_q[1] <= table_entry_i;
    for (int k = 2; k <= NST; k++) begin
      fn_q[k] <= fn_q[k-1];
    end
    for (int k = 2; k <= 12; k++) begin
      ti_q[k] <= ti_q[k-1];
      te_q[k] <= te_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Skew: s = floor(sum * F / 2^32), with the product split at bit 32.
  // ---------------------------------------------------------------------
  logic signed [47:0] c_q [1:4][3];
  logic signed [50:0] sum2_d, sum2_q;
  logic [31:0]        skc;
  logic [63:0]        skp;
  logic [31:0]        skl3_d, skl3_q;
  logic signed [51:0] skh3_d, skh3_q;
  logic signed [51:0] s4_d, s4_q;
  logic signed [52:0] xs5_d [3];
  logic signed [52:0] xs5_q [3];
  logic [XW-1:0]      s5_d, s5_q;

  always_comb begin
    sum2_d = 51'(c_q[1][0]) + 51'(c_q[1][1]) +
             ((fn_q[1] == FN_EVAL3) ? 51'(c_q[1][2]) : 51'sd0);
    skc    = (fn_q[2] == FN_EVAL3) ? SK_F3 : SK_F2;
    skp    = 64'(sum2_q[31:0]) * 64'(skc);
    skl3_d = skp[63:32];
    skh3_d = 52'($signed(sum2_q[50:32])) * 52'($signed({1'b0, skc}));
    s4_d   = skh3_q + $signed({20'd0, skl3_q});
    for (int a = 0; a < 3; a++) begin
      xs5_d[a] = 53'(c_q[4][a]) + 53'(s4_q);
    end
    s5_d = s4_q[XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    c_q[1][0] <= coord_x_i;
    c_q[1][1] <= coord_y_i;
    c_q[1][2] <= coord_z_i;
    for (int k = 2; k <= 4; k++) begin
      c_q[k] <= c_q[k-1];
    end
    sum2_q <= sum2_d;
    skl3_q <= skl3_d;
    skh3_q <= skh3_d;
    s4_q   <= s4_d;
    xs5_q  <= xs5_d;
    s5_q   <= s5_d;
  end

  // ---------------------------------------------------------------------
  // Cell index and unskew. Only the low XW bits of the offsets are kept,
  // which is exact because the offsets themselves are small.
  // ---------------------------------------------------------------------
  logic signed [52:0]   xi [3];
  logic [37:0]          nsum6_d, nsum6_q;
  logic signed [XW-1:0] px_d [3];
  logic signed [XW-1:0] px_q [6:8][3];
  cell_t                cell_d;
  cell_t                cell_q [6:12];
  logic [31:0]          gsel;
  logic [63:0]          tp;
  logic [11:0]          tph;
  logic [37:0]          tpl7_d, tpl7_q;
  logic [5:0]           tph7_d, tph7_q;
  logic [37:0]          tsum;
  logic [XW-1:0]        t8_d, t8_q;
  logic signed [XW-1:0] x0_d [3];
  logic signed [XW-1:0] x0_q [9:10][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      xi[a]   = xs5_q[a] >>> F;
      px_d[a] = {6'd0, xs5_q[a][F-1:0]} - s5_q;
    end
    nsum6_d = 38'(xi[0]) + 38'(xi[1]) + ((fn_q[5] == FN_EVAL3) ? 38'(xi[2]) : 38'd0);
    cell_d.ii = xs5_q[0][F+7:F];
    cell_d.jj = xs5_q[1][F+7:F];
    cell_d.kk = xs5_q[2][F+7:F];
    gsel   = (fn_q[6] == FN_EVAL3) ? UN_G3 : UN_G2;
    tp     = 64'(nsum6_q[31:0]) * 64'(gsel);
    tph    = 12'(nsum6_q[37:32]) * 12'(gsel[5:0]);
    tpl7_d = tp[37:0];
    tph7_d = tph[5:0];
    tsum   = {tph7_q, 32'd0} + tpl7_q;
    t8_d   = tsum[37:32-F];
    for (int a = 0; a < 3; a++) begin
      x0_d[a] = px_q[8][a] + $signed(t8_q);
    end
  end

  always_ff @(posedge clk_i) begin
    nsum6_q   <= nsum6_d;
    px_q[6]   <= px_d;
    px_q[7]   <= px_q[6];
    px_q[8]   <= px_q[7];
    cell_q[6] <= cell_d;
    for (int k = 7; k <= 12; k++) begin
      cell_q[k] <= cell_q[k-1];
    end
    tpl7_q   <= tpl7_d;
    tph7_q   <= tph7_d;
    t8_q     <= t8_d;
    x0_q[9]  <= x0_d;
    x0_q[10] <= x0_q[9];
  end

  // ---------------------------------------------------------------------
  // Simplex ordering. Each lane gets its corner offset as {a, b, c}.
  // Lane 3 is the far corner in 3D and unused in 2D.
  // ---------------------------------------------------------------------
  logic [2:0] off_d [4];
  logic [2:0] off_q [10:12][4];
  logic       ge_xy, ge_yz, ge_xz, gt_xy;

  always_comb begin
    ge_xy = x0_q[9][0] >= x0_q[9][1];
    ge_yz = x0_q[9][1] >= x0_q[9][2];
    ge_xz = x0_q[9][0] >= x0_q[9][2];
    gt_xy = x0_q[9][0] >  x0_q[9][1];
    off_d[0] = 3'b000;
    off_d[3] = 3'b111;
    if (fn_q[9] == FN_EVAL3) begin
      if (ge_xy) begin
        if (ge_yz) begin
          off_d[1] = 3'b100;
          off_d[2] = 3'b110;
        end else if (ge_xz) begin
          off_d[1] = 3'b100;
          off_d[2] = 3'b101;
        end else begin
          off_d[1] = 3'b001;
          off_d[2] = 3'b101;
        end
      end else if (!ge_yz) begin
        off_d[1] = 3'b001;
        off_d[2] = 3'b011;
      end else if (!ge_xz) begin
        off_d[1] = 3'b010;
        off_d[2] = 3'b011;
      end else begin
        off_d[1] = 3'b010;
        off_d[2] = 3'b110;
      end
    end else begin
      off_d[1] = {gt_xy, ~gt_xy, 1'b0};
      off_d[2] = 3'b110;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q[10] <= off_d;
    off_q[11] <= off_q[10];
    off_q[12] <= off_q[11];
  end

  // ---------------------------------------------------------------------
  // Permutation table: one copy per lookup level and lane pair, all holding
  // the same bytes. Each level's copies are written when a load passes the
  // stage where that level is read, so items keep their order against loads.
  // ---------------------------------------------------------------------
  logic [PERM_AW-1:0] raddr [3][4];
  logic [PERM_AW-1:0] rdat  [3][4];

  for (genvar lv = 0; lv < 3; lv++) begin : g_lvl
    logic               wr_en;
    logic [PERM_AW-1:0] wr_idx;
    logic [PERM_AW-1:0] wr_dat;

    assign wr_en  = vld_q[10+lv] && (fn_q[10+lv] == FN_LOAD);
    assign wr_idx = ti_q[10+lv];
    assign wr_dat = te_q[10+lv];

    for (genvar cp = 0; cp < 2; cp++) begin : g_copy
      logic [PERM_AW-1:0] perm_q [PERM_ENTRIES];
      logic [PERM_AW-1:0] rd0_q, rd1_q;

      always_ff @(posedge clk_i) begin
        if (wr_en) begin
          perm_q[wr_idx] <= wr_dat;
        end
        rd0_q <= perm_q[raddr[lv][2*cp]];
        rd1_q <= perm_q[raddr[lv][2*cp+1]];
      end

      assign rdat[lv][2*cp]   = rd0_q;
      assign rdat[lv][2*cp+1] = rd1_q;
    end
  end

  // 2D hashes skip the first level by treating its byte as zero.
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      raddr[0][n] = cell_q[10].kk + PERM_AW'(off_q[10][n][0]);
      raddr[1][n] = cell_q[11].jj + PERM_AW'(off_q[11][n][1]) +
                    ((fn_q[11] == FN_EVAL3) ? rdat[0][n] : '0);
      raddr[2][n] = cell_q[12].ii + PERM_AW'(off_q[12][n][2]) + rdat[1][n];
    end
  end

  // ---------------------------------------------------------------------
  // Corner positions and radial falloff, four lanes side by side.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0]    crd_d [4][3];
  logic signed [CW-1:0]    crd_q [11:14][4][3];
  logic signed [CW-1:0]    kofs;
  logic signed [2*CW-1:0]  sqp;
  logic [SQW-1:0]          sq_d [4][3];
  logic [SQW-1:0]          sq_q [4][3];
  logic [F+15:0]           radsel;
  logic signed [F+15:0]    tt;
  logic [F-1:0]            tc_d [4];
  logic [F-1:0]            tc_q [4];
  logic [2*F-1:0]          t2p, t4p;
  logic [F-1:0]            t2_d [4];
  logic [F-1:0]            t2_q [4];
  logic [3:0]              gi_d [4];
  logic [3:0]              gi_q [4];
  logic [F-1:0]            t4_d [4];
  logic [F-1:0]            t4_q [4];
  grad_t                   gv;
  logic signed [CW+1:0]    dot_d [4];
  logic signed [CW+1:0]    dot_q [4];

  function automatic logic signed [CW+1:0] axis_term(input logic [1:0] g,
                                                     input logic signed [CW-1:0] v);
    logic signed [CW+1:0] r;
    case (g)
      G_POS:   r = (CW+2)'(v);
      G_NEG:   r = -(CW+2)'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      if (fn_q[10] == FN_EVAL3) begin
        case (n)
          1:       kofs = G3_C;
          2:       kofs = G3X2_C;
          3:       kofs = ONE_C - HALF_C;
          default: kofs = '0;
        endcase
      end else begin
        case (n)
          1:       kofs = G2_C;
          2:       kofs = G2X2_C;
          default: kofs = '0;
        endcase
      end
      crd_d[n][0] = CW'(x0_q[10][0]) - (off_q[10][n][2] ? ONE_C : '0) + kofs;
      crd_d[n][1] = CW'(x0_q[10][1]) - (off_q[10][n][1] ? ONE_C : '0) + kofs;
      crd_d[n][2] = (fn_q[10] == FN_EVAL3) ?
                    CW'(x0_q[10][2]) - (off_q[10][n][0] ? ONE_C : '0) + kofs : '0;
    end

    for (int n = 0; n < 4; n++) begin
      for (int a = 0; a < 3; a++) begin
        sqp         = crd_q[11][n][a] * crd_q[11][n][a];
        sq_d[n][a]  = sqp[2*CW-1:F];
      end
    end

    radsel = (fn_q[12] == FN_EVAL3) ? RAD3_C : RAD2_C;
    for (int n = 0; n < 4; n++) begin
      tt = $signed(radsel) - $signed({2'b00, sq_q[n][0]})
                           - $signed({2'b00, sq_q[n][1]})
                           - $signed({2'b00, sq_q[n][2]});
      tc_d[n] = tt[F+15] ? '0 : tt[F-1:0];
    end

    for (int n = 0; n < 4; n++) begin
      t2p     = (2*F)'(tc_q[n]) * (2*F)'(tc_q[n]);
      t2_d[n] = t2p[2*F-1:F];
      gi_d[n] = grad_index(rdat[2][n]);
    end

    for (int n = 0; n < 4; n++) begin
      t4p      = (2*F)'(t2_q[n]) * (2*F)'(t2_q[n]);
      t4_d[n]  = t4p[2*F-1:F];
      gv       = grad_vec(gi_q[n]);
      dot_d[n] = axis_term(gv.gx, crd_q[14][n][0]) +
                 axis_term(gv.gy, crd_q[14][n][1]) +
                 axis_term(gv.gz, crd_q[14][n][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    crd_q[11] <= crd_d;
    crd_q[12] <= crd_q[11];
    crd_q[13] <= crd_q[12];
    crd_q[14] <= crd_q[13];
    sq_q      <= sq_d;
    tc_q      <= tc_d;
    t2_q      <= t2_d;
    gi_q      <= gi_d;
    t4_q      <= t4_d;
    dot_q     <= dot_d;
  end

  // ---------------------------------------------------------------------
  // Corner terms, their sum, scaling with rounding, and saturation.
  // ---------------------------------------------------------------------
  logic signed [TW-1:0]    term_d [4];
  logic signed [TW-1:0]    term_q [4];
  logic signed [AW2-1:0]   sum17_d, sum17_q;
  logic signed [SCW-1:0]   sext, scaled;
  logic signed [VW-1:0]    v18_d, v18_q;
  logic                    done_d, done_q;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      if (n == 3 && fn_q[15] != FN_EVAL3) begin
        term_d[n] = '0;
      end else begin
        term_d[n] = TW'($signed({1'b0, t4_q[n]})) * TW'(dot_q[n]);
      end
    end
    sum17_d = AW2'(term_q[0]) + AW2'(term_q[1]) + AW2'(term_q[2]) + AW2'(term_q[3]);

    // Scale by 32 for 3D and by 70 = 64 + 4 + 2 for 2D.
    sext = SCW'(sum17_q);
    if (fn_q[17] == FN_EVAL3) begin
      scaled = (sext <<< 5) + $signed(RND_C);
    end else begin
      scaled = (sext <<< 6) + (sext <<< 2) + (sext <<< 1) + $signed(RND_C);
    end
    v18_d = scaled[SCW-1:F];

    if (v18_q > VMAX_C) begin
      noise_d = NOISE_W'(VMAX_C);
    end else if (v18_q < VMIN_C) begin
      noise_d = NOISE_W'(VMIN_C);
    end else begin
      noise_d = v18_q[NOISE_W-1:0];
    end
    done_d = vld_q[NST] && (fn_q[NST] == FN_EVAL2 || fn_q[NST] == FN_EVAL3);
  end

  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    sum17_q <= sum17_d;
    v18_q   <= v18_d;
    noise_q <= noise_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign done_o        = done_q;
  assign noise_value_o = noise_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import snoise_pkg::*;

  // One command as presented on the input ports.
  typedef struct {
    func_t             func;
    logic [7:0]        idx;
    logic [7:0]        entry;
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
  } noise_cmd_t;

  localparam int  LATENCY     = 19;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  RANDOM_CMDS = 1676;
  localparam longint ONE_FX   = 64'sd1 << 16;

  // The twelve gradient directions, one array per component.
  localparam int GRAD_X [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  localparam int GRAD_Y [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
  localparam int GRAD_Z [12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  func_t              func_i;
  logic [7:0]         table_index_i;
  logic [7:0]         table_entry_i;
  logic signed [47:0] coord_x_i;
  logic signed [47:0] coord_y_i;
  logic signed [47:0] coord_z_i;
  logic               done_o;
  logic signed [NOISE_W-1:0] noise_value_o;

  simplex_noise_2d_3d dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .table_index_i (table_index_i),
    .table_entry_i (table_entry_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .done_o        (done_o),
    .noise_value_o (noise_value_o)
  );

  noise_cmd_t                pending_cmds[$];
  logic signed [NOISE_W-1:0] expected_noise[$];
  logic [7:0]                perm_bytes[256];
  int                        errors;
  int                        cycles;
  int                        sent;
  int                        idle_pct;
  bit                        stim_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycles, what);
    errors++;
  endtask

  // floor(v * c / 2^32) with a wide product so large coordinates do not wrap.
  function automatic longint skew_mul(input longint v, input logic [31:0] c);
    logic signed [127:0] p;
    p = v;
    p = p * $signed({96'd0, c});
    return longint'(p >>> 32);
  endfunction

  // A Q0.32 constant rounded to 16 fraction bits.
  function automatic longint round_q16(input logic [31:0] c);
    return longint'(({32'd0, c} + 64'd32768) >> 16);
  endfunction

  function automatic int perm_at(input longint i);
    return int'(perm_bytes[i & 255]);
  endfunction

  // Radial falloff of one corner times its gradient dot product, in Q.32.
  function automatic longint falloff_term(input int h, input longint x, input longint y,
                                          input longint z, input longint rad);
    longint t, t2, t4, d;
    t = rad - ((x * x) >>> 16) - ((y * y) >>> 16) - ((z * z) >>> 16);
    if (t < 0) return 0;
    t2 = (t * t) >>> 16;
    t4 = (t2 * t2) >>> 16;
    d  = GRAD_X[h] * x + GRAD_Y[h] * y + GRAD_Z[h] * z;
    return t4 * d;
  endfunction

  function automatic logic signed [NOISE_W-1:0] scale_sat(input longint sum,
                                                           input longint scale);
    longint v;
    v = (sum * scale + 32768) >>> 16;
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return NOISE_W'(v);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_2d(input longint x, input longint y);
    longint s, i, j, t, g2, x0, y0, sum;
    int     i1, j1, h0, h1, h2;
    s  = skew_mul(x + y, SK_F2);
    i  = (x + s) >>> 16;
    j  = (y + s) >>> 16;
    t  = skew_mul((i + j) * ONE_FX, UN_G2);
    g2 = round_q16(UN_G2);
    x0 = x - i * ONE_FX + t;
    y0 = y - j * ONE_FX + t;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    i  = i & 255;
    j  = j & 255;
    h0 = perm_at(i + perm_at(j)) % 12;
    h1 = perm_at(i + i1 + perm_at(j + j1)) % 12;
    h2 = perm_at(i + 1 + perm_at(j + 1)) % 12;
    sum = falloff_term(h0, x0, y0, 0, ONE_FX / 2);
    sum += falloff_term(h1, x0 - i1 * ONE_FX + g2, y0 - j1 * ONE_FX + g2, 0, ONE_FX / 2);
    sum += falloff_term(h2, x0 - ONE_FX + 2 * g2, y0 - ONE_FX + 2 * g2, 0, ONE_FX / 2);
    return scale_sat(sum, 70);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_3d(input longint x, input longint y,
                                                          input longint z);
    longint s, i, j, k, t, g3, rad, half, x0, y0, z0, sum;
    int     a1, b1, c1, a2, b2, c2, h0, h1, h2, h3;
    s    = skew_mul(x + y + z, SK_F3);
    i    = (x + s) >>> 16;
    j    = (y + s) >>> 16;
    k    = (z + s) >>> 16;
    t    = skew_mul((i + j + k) * ONE_FX, UN_G3);
    g3   = round_q16(UN_G3);
    rad  = round_q16(RAD_06);
    half = ONE_FX / 2;
    x0   = x - i * ONE_FX + t;
    y0   = y - j * ONE_FX + t;
    z0   = z - k * ONE_FX + t;
    // Six-way ordering of the offsets picks the two middle corners.
    if (x0 >= y0) begin
      if (y0 >= z0) begin
        a1 = 1; b1 = 0; c1 = 0; a2 = 1; b2 = 1; c2 = 0;
      end else if (x0 >= z0) begin
        a1 = 1; b1 = 0; c1 = 0; a2 = 1; b2 = 0; c2 = 1;
      end else begin
        a1 = 0; b1 = 0; c1 = 1; a2 = 1; b2 = 0; c2 = 1;
      end
    end else if (y0 < z0) begin
      a1 = 0; b1 = 0; c1 = 1; a2 = 0; b2 = 1; c2 = 1;
    end else if (x0 < z0) begin
      a1 = 0; b1 = 1; c1 = 0; a2 = 0; b2 = 1; c2 = 1;
    end else begin
      a1 = 0; b1 = 1; c1 = 0; a2 = 1; b2 = 1; c2 = 0;
    end
    i = i & 255;
    j = j & 255;
    k = k & 255;
    h0 = perm_at(i + perm_at(j + perm_at(k))) % 12;
    h1 = perm_at(i + a1 + perm_at(j + b1 + perm_at(k + c1))) % 12;
    h2 = perm_at(i + a2 + perm_at(j + b2 + perm_at(k + c2))) % 12;
    h3 = perm_at(i + 1 + perm_at(j + 1 + perm_at(k + 1))) % 12;
    sum = falloff_term(h0, x0, y0, z0, rad);
    sum += falloff_term(h1, x0 - a1 * ONE_FX + g3, y0 - b1 * ONE_FX + g3,
                        z0 - c1 * ONE_FX + g3, rad);
    sum += falloff_term(h2, x0 - a2 * ONE_FX + 2 * g3, y0 - b2 * ONE_FX + 2 * g3,
                        z0 - c2 * ONE_FX + 2 * g3, rad);
    sum += falloff_term(h3, x0 - half, y0 - half, z0 - half, rad);
    return scale_sat(sum, 32);
  endfunction

  // Mostly small coordinates near the origin, sometimes any 48-bit value.
  function automatic logic signed [47:0] rand_coord();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    return r[47:0];
      2:       return $urandom_range(0, 1) ? 48'sh7FFFFFFFFFFF : 48'sh800000000000;
      default: return 48'($signed(r[21:0]));
    endcase
  endfunction

  function automatic noise_cmd_t make_cmd(input func_t f, input logic signed [47:0] x,
                                          input logic signed [47:0] y,
                                          input logic signed [47:0] z);
    noise_cmd_t c;
    c.func  = f;
    c.idx   = 8'($urandom);
    c.entry = 8'($urandom);
    c.x = x;
    c.y = y;
    c.z = z;
    return c;
  endfunction

  // Stimulus: fill the whole table first, then directed and random commands.
  initial begin
    noise_cmd_t c;
    int         order[256];
    int         tmp, r, sel;
    for (int n = 0; n < 256; n++) order[n] = n;
    for (int n = 255; n > 0; n--) begin
      r = $urandom_range(0, n);
      tmp = order[n];
      order[n] = order[r];
      order[r] = tmp;
    end
    for (int n = 0; n < 256; n++) begin
      c = make_cmd(FN_LOAD, 0, 0, 0);
      c.idx   = 8'(n);
      c.entry = 8'(order[n]);
      pending_cmds.push_back(c);
    end
    // Origin, coordinate extremes and an unknown code that must be ignored.
    pending_cmds.push_back(make_cmd(FN_EVAL2, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL2, 48'sh7FFFFFFFFFFF, 48'sh800000000000, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh7FFFFFFFFFFF, 48'sh7FFFFFFFFFFF,
                                    48'sh7FFFFFFFFFFF));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh800000000000, 48'sh800000000000,
                                    48'sh800000000000));
    pending_cmds.push_back(make_cmd(func_t'(2'd3), 48'sh1234, 48'sh5678, 48'sh9ABC));
    pending_cmds.push_back(make_cmd(FN_EVAL2, 48'sh18000, 48'sh04000, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL2, 48'sh04000, 48'sh18000, 0));
    // All six orderings of the 3D offsets inside one cell.
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh4000, 48'sh2000, 48'sh1000));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh4000, 48'sh1000, 48'sh2000));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh2000, 48'sh1000, 48'sh4000));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh1000, 48'sh2000, 48'sh4000));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh1000, 48'sh4000, 48'sh2000));
    pending_cmds.push_back(make_cmd(FN_EVAL3, 48'sh2000, 48'sh4000, 48'sh1000));
    pending_cmds.push_back(make_cmd(FN_EVAL2, -48'sh2A000, -48'sh11000, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL3, -48'sh2A000, 48'sh11000, -48'sh3000));
    // A reload of one random table entry right before an evaluation.
    pending_cmds.push_back(make_cmd(FN_LOAD, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_EVAL2, 48'sh8000, 48'sh3000, 0));
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8)       c = make_cmd(FN_LOAD, 0, 0, 0);
      else if (sel < 11) c = make_cmd(func_t'(2'd3), rand_coord(), rand_coord(), rand_coord());
      else if (sel < 55) c = make_cmd(FN_EVAL2, rand_coord(), rand_coord(), rand_coord());
      else               c = make_cmd(FN_EVAL3, rand_coord(), rand_coord(), rand_coord());
      pending_cmds.push_back(c);
    end
    stim_done = 1'b1;
  end

  // Reset and default values for every input.
  initial begin
    errors        = 0;
    cycles        = 0;
    sent          = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = FN_LOAD;
    table_index_i = '0;
    table_entry_i = '0;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // The sender idles 18% of cycles, then 72%, then never.
  always_comb begin
    if (sent < 700)       idle_pct = 18;
    else if (sent < 1400) idle_pct = 72;
    else                  idle_pct = 0;
  end

  // Driver: present the oldest pending command at the falling edge. The queue
  // is popped by the monitor when a transfer happens, so the front is always
  // the next command still to go.
  always @(negedge clk_i) begin
    if (rst_ni && pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      start         <= 1'b1;
      func_i        <= pending_cmds[0].func;
      table_index_i <= pending_cmds[0].idx;
      table_entry_i <= pending_cmds[0].entry;
      coord_x_i     <= pending_cmds[0].x;
      coord_y_i     <= pending_cmds[0].y;
      coord_z_i     <= pending_cmds[0].z;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check each strobed result against the oldest expectation, then
  // record the transfer of this edge and predict what it must produce.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", noise_value_o));
        end else begin
          if (noise_value_o !== expected_noise[0])
            report_mismatch($sformatf("noise_value got %0d want %0d",
                                      noise_value_o, expected_noise[0]));
          void'(expected_noise.pop_front());
        end
      end
      if (start && !busy) begin
        case (func_i)
          FN_LOAD:  perm_bytes[table_index_i] = table_entry_i;
          FN_EVAL2: expected_noise.push_back(noise_2d(coord_x_i, coord_y_i));
          FN_EVAL3: expected_noise.push_back(noise_3d(coord_x_i, coord_y_i, coord_z_i));
          default: ;
        endcase
        void'(pending_cmds.pop_front());
        sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Once everything is sent and answered, give the pipeline time to show any
  // stray result before deciding.
  initial begin
    wait (stim_done);
    wait (pending_cmds.size() == 0 && expected_noise.size() == 0);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (errors == 0 && expected_noise.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_noise.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_noise.size()));
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
